// File: hw/rtl/gbc_pkg.sv
// gbc_pkg: shared types, S-box table and round function for the 64-bit block cipher.
// No dependencies; used by every module under hw/rtl.
package gbc_pkg;

    localparam int unsigned NumKeys   = 8;
    localparam int unsigned NumRounds = 32;
    localparam int unsigned RotAmount = 11;
    localparam int unsigned KeyIdxW   = 3;

    typedef logic [31:0] t_word;
    typedef logic [KeyIdxW-1:0] t_key_idx;
    typedef logic [NumKeys-1:0][31:0] t_key_set;

    // Input word: N1 (high), N2 (low) and the key order select
    typedef struct packed {
        logic [31:0] block_high;
        logic [31:0] block_low;
        logic        decrypt;
    } t_in_word;

    typedef struct packed {
        logic [31:0] result_high;
        logic [31:0] result_low;
    } t_out_word;

    // Data carried between round stages
    typedef struct packed {
        logic [31:0] n1;
        logic [31:0] n2;
        logic        dec;
    } t_stage;

    function automatic logic [3:0] sbox_row0(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'h5, 4'hD, 4'h0, 4'hC, 4'hF, 4'hE, 4'h4, 4'hA,
             4'h7, 4'h1, 4'hB, 4'h8, 4'h2, 4'h3, 4'h6, 4'h9};
        return t[c];
    endfunction

    function automatic logic [3:0] sbox_row1(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'h1, 4'hD, 4'h4, 4'hB, 4'hC, 4'h6, 4'h2, 4'h5,
             4'h0, 4'hF, 4'hA, 4'h8, 4'h9, 4'hE, 4'h7, 4'h3};
        return t[c];
    endfunction

    function automatic logic [3:0] sbox_row2(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'h9, 4'h1, 4'h7, 4'h0, 4'hA, 4'h5, 4'hF, 4'hC,
             4'h8, 4'hD, 4'h3, 4'hB, 4'h2, 4'h6, 4'h4, 4'hE};
        return t[c];
    endfunction

    function automatic logic [3:0] sbox_row3(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'h6, 4'h5, 4'h8, 4'hF, 4'h4, 4'hB, 4'h2, 4'h0,
             4'h9, 4'h3, 4'h1, 4'hD, 4'hC, 4'hA, 4'h7, 4'hE};
        return t[c];
    endfunction

    function automatic logic [3:0] sbox_row4(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'h6, 4'hA, 4'h7, 4'hC, 4'h3, 4'h2, 4'h4, 4'hE,
             4'h0, 4'hF, 4'hD, 4'h8, 4'h9, 4'h1, 4'h5, 4'hB};
        return t[c];
    endfunction

    function automatic logic [3:0] sbox_row5(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'h6, 4'hE, 4'hF, 4'h8, 4'h4, 4'h9, 4'h5, 4'h7,
             4'hB, 4'h0, 4'h2, 4'h1, 4'hC, 4'hD, 4'hA, 4'h3};
        return t[c];
    endfunction

    function automatic logic [3:0] sbox_row6(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'hE, 4'hB, 4'h3, 4'hF, 4'h5, 4'h4, 4'hC, 4'h8,
             4'h0, 4'h6, 4'hA, 4'h7, 4'h9, 4'h2, 4'hD, 4'h1};
        return t[c];
    endfunction

    function automatic logic [3:0] sbox_row7(input logic [3:0] c);
        logic [15:0][3:0] t;
        t = {4'h4, 4'hD, 4'h7, 4'h1, 4'h9, 4'h3, 4'h2, 4'h6,
             4'h8, 4'hE, 4'hC, 4'h0, 4'h5, 4'hF, 4'hA, 4'hB};
        return t[c];
    endfunction

    function automatic logic [3:0] gbc_sbox_lookup(input logic [2:0] row,
                                                  input logic [3:0] col);
        logic [3:0] v;
        v = 4'h0;
        case (row)
            3'd0: v = sbox_row0(col);
            3'd1: v = sbox_row1(col);
            3'd2: v = sbox_row2(col);
            3'd3: v = sbox_row3(col);
            3'd4: v = sbox_row4(col);
            3'd5: v = sbox_row5(col);
            3'd6: v = sbox_row6(col);
            3'd7: v = sbox_row7(col);
            default: v = 4'h0;
        endcase
        return v;
    endfunction

    // Substitute each nibble through its own S-box
    function automatic t_word sbox_word(input t_word w);
        t_word r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            r[4*k +: 4] = gbc_sbox_lookup(k[2:0], w[4*k +: 4]);
        end
        return r;
    endfunction

    // Round function: add key mod 2^32, substitute, rotate left
    function automatic t_word round_fn(input t_word half, input t_word key);
        t_word t;
        t_word s;
        t = half + key;
        s = sbox_word(t);
        return {s[31-RotAmount:0], s[31:32-RotAmount]};
    endfunction

endpackage

// File: hw/rtl/gbc_key_file.sv
// gbc_key_file: the eight 32-bit key word registers behind the write port.
// Depends on gbc_pkg.
module gbc_key_file
    import gbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_key_idx i_cfg_idx,
    input  t_word    i_cfg_data,
    output t_key_set o_keys
);

    t_key_set r_keys;
    t_key_set n_keys;

    // Replace the addressed key word
    always_comb begin
        n_keys = r_keys;
        if (i_cfg_we) begin
            n_keys[i_cfg_idx] = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else begin
            r_keys <= n_keys;
        end
    end

    assign o_keys = r_keys;

endmodule

// File: hw/rtl/gbc_round.sv
// gbc_round: one Feistel round with its stage register and valid bit.
// Depends on gbc_pkg (t_stage, round_fn).
module gbc_round
    import gbc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    input  t_word  i_key,
    input  logic   i_ready,
    output logic   o_valid,
    output t_stage o_stage,
    output logic   o_ready
);

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    // Advance when this stage is empty or the next one takes its word
    assign o_ready = !r_valid || i_ready;

    // Mix N1 into N2 and swap the halves
    always_comb begin
        n_stage.n1  = i_stage.n2 ^ round_fn(i_stage.n1, i_key);
        n_stage.n2  = i_stage.n1;
        n_stage.dec = i_stage.dec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// File: hw/rtl/gost_block_cipher_64.sv
// gost_block_cipher_64: 32-round Feistel block cipher, one round per pipeline stage.
// Throughput: one word/cycle while the output side does not stall (i_stall low).
// Each stage holds a word until the next stage takes it; bubbles collapse under stall.
// Reset (synchronous, active low) clears all stage valid bits and the key words to zero.
// Depends on gbc_pkg, gbc_key_file and gbc_round.
module gost_block_cipher_64
    import gbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_key_idx  i_cfg_idx,
    input  t_word     i_cfg_data,
    input  logic      i_valid,
    input  t_in_word  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_word o_data,
    input  logic      i_stall
);

    t_key_set w_keys;
    logic     w_valid [NumRounds+1];
    t_stage   w_stage [NumRounds+1];
    logic     w_ready [NumRounds+1];

    gbc_key_file u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_keys     (w_keys)
    );

    // Feed the first round from the input word
    assign w_valid[0] = i_valid;
    assign w_stage[0] = t_stage'{n1: i_data.block_high, n2: i_data.block_low,
                                 dec: i_data.decrypt};
    assign o_stall    = !w_ready[0];

    // One round per stage; key order fixed per stage, picked by the word's direction
    for (genvar r = 0; r < NumRounds; r++) begin : g_round
        localparam int unsigned EncIdx = (r < 24) ? (r % 8) : (7 - (r % 8));
        localparam int unsigned DecIdx = (r < 8)  ? (r % 8) : (7 - (r % 8));
        t_word w_key;

        assign w_key = w_stage[r].dec ? w_keys[DecIdx[KeyIdxW-1:0]]
                                      : w_keys[EncIdx[KeyIdxW-1:0]];

        gbc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[r]),
            .i_stage (w_stage[r]),
            .i_key   (w_key),
            .i_ready (w_ready[r+1]),
            .o_valid (w_valid[r+1]),
            .o_stage (w_stage[r+1]),
            .o_ready (w_ready[r])
        );
    end

    // Last stage register is the output register: final N2 high, final N1 low
    assign w_ready[NumRounds] = !i_stall;
    assign o_valid            = w_valid[NumRounds];
    assign o_data             = t_out_word'{result_high: w_stage[NumRounds].n2,
                                            result_low:  w_stage[NumRounds].n1};

    // Free output side means no back-pressure anywhere in the pipe
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side is free");

    // Stall on the input only when the first stage holds a word
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_valid[1])
        else $error("input stalled with first stage empty");

    // An accepted input word reaches the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_valid[1])
        else $error("accepted word lost at first stage");

endmodule
